@@ rtl/cgp_pkg.sv @@
// Shared types, constants and gate functions of the genome fitness evaluator.
package cgp_pkg;

  localparam int NODE_COUNT = 64;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int MAX_INPUTS = 16;
  localparam int ROW_BITS   = 16;
  localparam int SRC_W      = 7;
  localparam int ICNT_W     = 5;
  localparam int GATE_W     = 4;
  localparam int HIT_W      = 17;
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  localparam logic [0:0] CFG_INPUT_COUNT   = 1'd0;
  localparam logic [0:0] CFG_OUTPUT_SOURCE = 1'd1;

  typedef enum logic [GATE_W-1:0] {
    G_AND    = 4'd0,
    G_OR     = 4'd1,
    G_NAND   = 4'd2,
    G_NOR    = 4'd3,
    G_XOR    = 4'd4,
    G_XNOR   = 4'd5,
    G_A_NB   = 4'd6,
    G_A      = 4'd7,
    G_NA_B   = 4'd8,
    G_B      = 4'd9,
    G_NB     = 4'd10,
    G_A_OR_NB = 4'd11,
    G_NA     = 4'd12,
    G_B_OR_NA = 4'd13
  } gate_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src_a;
    logic [SRC_W-1:0]  src_b;
    logic [GATE_W-1:0] gate;
  } gene_t;

  localparam int GENE_W = $bits(gene_t);

  function automatic logic gate_eval(logic a, logic b, logic [GATE_W-1:0] g);
    logic r;
    case (g)
      G_AND:     r = a & b;
      G_OR:      r = a | b;
      G_NAND:    r = ~(a & b);
      G_NOR:     r = ~(a | b);
      G_XOR:     r = a ^ b;
      G_XNOR:    r = ~(a ^ b);
      G_A_NB:    r = a & ~b;
      G_A:       r = a;
      G_NA_B:    r = ~a & b;
      G_B:       r = b;
      G_NB:      r = ~b;
      G_A_OR_NB: r = a | ~b;
      G_NA:      r = ~a;
      G_B_OR_NA: r = b | ~a;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  // A source below the input count is a primary input; anything else is a node,
  // which reads 0 unless it lies below the limit and inside the genome.
  function automatic logic src_value(logic [SRC_W-1:0] src, logic [ICNT_W-1:0] icnt,
                                     logic [ROW_BITS-1:0] row,
                                     logic [NODE_COUNT-1:0] nv,
                                     logic [NODE_W:0] limit);
    logic [SRC_W-1:0] n;
    logic r;
    n = src - SRC_W'(icnt);
    if (src < SRC_W'(icnt)) begin
      if (int'(src) >= ROW_BITS || int'(src) >= MAX_INPUTS) r = 1'b0;
      else r = row[src[$clog2(ROW_BITS)-1:0]];
    end else if (int'(n) >= int'(limit) || int'(n) >= NODE_COUNT) begin
      r = 1'b0;
    end else begin
      r = nv[NODE_W'(n)];
    end
    return r;
  endfunction

endpackage

@@ rtl/cgp_genome_mem.sv @@
// Genome node store: single-port-per-side RAM with per-entry valid bits.
module cgp_genome_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [cgp_pkg::NODE_W-1:0]   wr_addr,
  input  cgp_pkg::gene_t               wr_data,
  input  logic                         rd_en,
  input  logic [cgp_pkg::NODE_W-1:0]   rd_addr,
  output cgp_pkg::gene_t               rd_data
);
  import cgp_pkg::*;

  gene_t                 mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] valid;
  gene_t                 rd_q;
  logic                  rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entries never written read as zero, matching the cleared genome after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

@@ rtl/cgp_logic_genome_fitness_top.sv @@
// Top level of the genome fitness evaluator: control sequencer, node values and hit count.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready  | kind, node_index, source_a, source_b,
//          |           |                      | gate_code, row_inputs, expected_bit, last_row
//  out     | output    | out_valid / out_ready| row_match, hit_count, final_result
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A node-write transaction gives no result. A row transaction reads the genome store one node
// per cycle and evaluates each node in the cycle after its read.
// The result sits in an output register, so the next transaction is taken while it waits;
// a finished row holds in the done state only while an older result is still unread.
// Reset is synchronous and clears the genome (through valid bits), node values and the count.
module cgp_logic_genome_fitness_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [cgp_pkg::NODE_W-1:0]   node_index,
  input  logic [cgp_pkg::SRC_W-1:0]    source_a,
  input  logic [cgp_pkg::SRC_W-1:0]    source_b,
  input  logic [cgp_pkg::GATE_W-1:0]   gate_code,
  input  logic [cgp_pkg::ROW_BITS-1:0] row_inputs,
  input  logic                         expected_bit,
  input  logic                         last_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         row_match,
  output logic [cgp_pkg::HIT_W-1:0]    hit_count,
  output logic                         final_result,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [cgp_pkg::SRC_W-1:0]    cfg_data
);
  import cgp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DONE} state_t;

  state_t                state;
  logic [ICNT_W-1:0]     input_count;
  logic [SRC_W-1:0]      output_source;
  logic [ROW_BITS-1:0]   row_q;
  logic                  expected_q;
  logic                  last_q;
  logic [NODE_W-1:0]     issue_idx;
  logic                  issuing;
  logic                  rd_vld;
  logic [NODE_W-1:0]     rd_idx;
  logic [NODE_COUNT-1:0] node_values;
  logic [HIT_W-1:0]      hits;

  logic                  in_acc;
  logic                  wr_en;
  logic                  rd_en;
  gene_t                 wr_gene;
  gene_t                 gene;
  logic                  node_bit;
  logic                  result;
  logic                  match;
  logic [HIT_W-1:0]      hits_next;
  logic                  load;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (kind == KIND_NODE);
  assign rd_en    = (state == S_EVAL) && issuing;
  assign wr_gene  = '{src_a: source_a, src_b: source_b, gate: gate_code};

  cgp_genome_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (node_index),
    .wr_data (wr_gene),
    .rd_en   (rd_en),
    .rd_addr (issue_idx),
    .rd_data (gene)
  );

  // Node k only looks at nodes below k, all of which were written in earlier cycles.
  assign node_bit = gate_eval(
      src_value(gene.src_a, input_count, row_q, node_values, (NODE_W+1)'(rd_idx)),
      src_value(gene.src_b, input_count, row_q, node_values, (NODE_W+1)'(rd_idx)),
      gene.gate);

  assign result    = src_value(output_source, input_count, row_q, node_values,
                               (NODE_W+1)'(NODE_COUNT));
  assign match     = (result == expected_q);
  assign hits_next = (match && hits != HIT_MAX) ? hits + HIT_W'(1) : hits;
  assign load      = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      input_count   <= ICNT_W'(1);
      output_source <= '0;
      issuing       <= 1'b0;
      issue_idx     <= '0;
      rd_vld        <= 1'b0;
      node_values   <= '0;
      hits          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_INPUT_COUNT:   input_count   <= cfg_data[ICNT_W-1:0];
          CFG_OUTPUT_SOURCE: output_source <= cfg_data;
          default: ;
        endcase
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      rd_vld <= rd_en;
      if (rd_en) begin
        rd_idx <= issue_idx;
        if (issue_idx == NODE_W'(NODE_COUNT - 1)) begin
          issuing <= 1'b0;
        end else begin
          issue_idx <= issue_idx + NODE_W'(1);
        end
      end

      if (rd_vld) begin
        node_values[rd_idx] <= node_bit;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && kind == KIND_ROW) begin
            row_q      <= row_inputs;
            expected_q <= expected_bit;
            last_q     <= last_row;
            issue_idx  <= '0;
            issuing    <= 1'b1;
            state      <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (rd_vld && rd_idx == NODE_W'(NODE_COUNT - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            row_match    <= match;
            hit_count    <= hits_next;
            final_result <= last_q;
            hits         <= last_q ? '0 : hits_next;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rd_in_eval: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == S_EVAL)
    else $error("node read returned outside evaluation");

  a_row_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && kind == KIND_ROW |=> issuing && issue_idx == '0)
    else $error("row transaction did not start at node zero");

  a_last_node_done: assert property (@(posedge clk) disable iff (rst)
    rd_vld && rd_idx == NODE_W'(NODE_COUNT - 1) |=> state == S_DONE)
    else $error("evaluation did not finish after the last node");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && last_q |=> hits == '0)
    else $error("hit count not cleared after the last row");

  a_no_write_during_eval: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("genome write overlaps evaluation");

endmodule
